// ----- rtl/core/bpsc_pkg.sv -----
`timescale 1ns / 1ps

package bpsc_pkg;

    localparam int COORD_W = 32;
    localparam int EXT_W   = 31;
    localparam int IDX_W   = 3;
    localparam int MASK_W  = 8;
    localparam int OFF_SH  = 16;

    localparam int PROD_W  = 2 * COORD_W;
    localparam int MAG_W   = EXT_W + COORD_W;
    localparam int OFFS_W  = COORD_W + OFF_SH;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TEST  = 1'b1;

    typedef struct packed {
        logic                      func;
        logic [IDX_W-1:0]          plane_index;
        logic signed [COORD_W-1:0] normal_x;
        logic signed [COORD_W-1:0] normal_y;
        logic signed [COORD_W-1:0] normal_z;
        logic signed [COORD_W-1:0] plane_offset;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic [EXT_W-1:0]          extent_x;
        logic [EXT_W-1:0]          extent_y;
        logic [EXT_W-1:0]          extent_z;
    } item_t;

    typedef struct packed {
        logic              is_outside;
        logic [MASK_W-1:0] reject_mask;
    } result_t;

endpackage

// ----- rtl/core/bpsc_item_if.sv -----
`timescale 1ns / 1ps

interface bpsc_item_if import bpsc_pkg::*; ();

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/core/bpsc_result_if.sv -----
`timescale 1ns / 1ps

interface bpsc_result_if import bpsc_pkg::*; ();

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ----- rtl/core/box_plane_set_cull.sv -----
`timescale 1ns / 1ps

// Culls an axis-aligned box (center Q16.16, half-extent unsigned Q15.16) against a
// table of planes. A plane write (func = 0) loads one table entry in the cycle it is
// transferred and gives no result. A box test (func = 1) gives one result, which passes
// through the stage chain: input register, 32x32 and 31x32 multipliers (six per plane,
// all planes in parallel), two adder levels and the per-plane compare feeding the
// output register. A new item is taken every cycle unless the result side stalls.
// A plane tests outside when dot(center, normal) - offset > dot(extent, |normal|), exact
// at full width; planes beyond the eighth are never written and never reject. The table
// clears to zero on reset.
module box_plane_set_cull import bpsc_pkg::*; #(
    parameter int NUM_PLANES = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    bpsc_item_if.sink     item,
    bpsc_result_if.source result
);

    localparam int LANES = (NUM_PLANES < MASK_W) ? NUM_PLANES : MASK_W;

    // plane table
    logic signed [COORD_W-1:0] nx_reg  [LANES];
    logic signed [COORD_W-1:0] ny_reg  [LANES];
    logic signed [COORD_W-1:0] nz_reg  [LANES];
    logic signed [COORD_W-1:0] off_reg [LANES];
    logic [COORD_W-1:0]        ax_reg  [LANES];
    logic [COORD_W-1:0]        ay_reg  [LANES];
    logic [COORD_W-1:0]        az_reg  [LANES];

    // stage 1: box operands
    logic                      s1_valid_reg;
    logic signed [COORD_W-1:0] cx_reg;
    logic signed [COORD_W-1:0] cy_reg;
    logic signed [COORD_W-1:0] cz_reg;
    logic [EXT_W-1:0]          ex_reg;
    logic [EXT_W-1:0]          ey_reg;
    logic [EXT_W-1:0]          ez_reg;

    // stage 2: products
    logic                      s2_valid_reg;
    logic signed [PROD_W-1:0]  px_reg   [LANES];
    logic signed [PROD_W-1:0]  py_reg   [LANES];
    logic signed [PROD_W-1:0]  pz_reg   [LANES];
    logic signed [OFFS_W-1:0]  poff_reg [LANES];
    logic [MAG_W-1:0]          mx_reg   [LANES];
    logic [MAG_W-1:0]          my_reg   [LANES];
    logic [MAG_W-1:0]          mz_reg   [LANES];

    // stage 3: first adder level
    logic                      s3_valid_reg;
    logic signed [PROD_W:0]    pa_reg [LANES];
    logic signed [PROD_W:0]    pb_reg [LANES];
    logic [MAG_W:0]            pc_reg [LANES];
    logic [MAG_W-1:0]          pd_reg [LANES];

    // stage 4: distance and radius
    logic                      s4_valid_reg;
    logic signed [PROD_W+1:0]  da_reg [LANES];
    logic [MAG_W+1:0]          ra_reg [LANES];

    // output register
    logic                      out_valid_reg;
    logic                      outside_reg;
    logic [MASK_W-1:0]         mask_reg;

    logic              out_ready;
    logic              s4_ready;
    logic              s3_ready;
    logic              s2_ready;
    logic              s1_ready;
    logic              in_xfer;
    logic              wr_xfer;
    logic              test_xfer;
    logic [LANES-1:0]  lane_rej;
    logic [MASK_W-1:0] mask_next;

    assign out_ready = !out_valid_reg || result.ready;
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    assign item.ready = s1_ready;
    assign in_xfer    = item.valid && s1_ready;
    assign wr_xfer    = in_xfer && (item.data.func == FUNC_WRITE);
    assign test_xfer  = in_xfer && (item.data.func == FUNC_TEST);

    assign result.valid            = out_valid_reg;
    assign result.data.is_outside  = outside_reg;
    assign result.data.reject_mask = mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= test_xfer;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            cx_reg <= item.data.center_x;
            cy_reg <= item.data.center_y;
            cz_reg <= item.data.center_z;
            ex_reg <= item.data.extent_x;
            ey_reg <= item.data.extent_y;
            ez_reg <= item.data.extent_z;
        end
    end

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                nx_reg[l]  <= '0;
                ny_reg[l]  <= '0;
                nz_reg[l]  <= '0;
                off_reg[l] <= '0;
                ax_reg[l]  <= '0;
                ay_reg[l]  <= '0;
                az_reg[l]  <= '0;
            end
            else if (wr_xfer && (item.data.plane_index == IDX_W'(l)))
            begin
                nx_reg[l]  <= item.data.normal_x;
                ny_reg[l]  <= item.data.normal_y;
                nz_reg[l]  <= item.data.normal_z;
                off_reg[l] <= item.data.plane_offset;
                // magnitude of the most negative code wraps to 2^31 unsigned
                ax_reg[l]  <= item.data.normal_x[COORD_W-1] ?
                              COORD_W'(-item.data.normal_x) : COORD_W'(item.data.normal_x);
                ay_reg[l]  <= item.data.normal_y[COORD_W-1] ?
                              COORD_W'(-item.data.normal_y) : COORD_W'(item.data.normal_y);
                az_reg[l]  <= item.data.normal_z[COORD_W-1] ?
                              COORD_W'(-item.data.normal_z) : COORD_W'(item.data.normal_z);
            end
        end

        always_ff @(posedge clk)
        begin
            if (s2_ready)
            begin
                px_reg[l]   <= PROD_W'(cx_reg) * PROD_W'(nx_reg[l]);
                py_reg[l]   <= PROD_W'(cy_reg) * PROD_W'(ny_reg[l]);
                pz_reg[l]   <= PROD_W'(cz_reg) * PROD_W'(nz_reg[l]);
                poff_reg[l] <= {off_reg[l], {OFF_SH{1'b0}}};
                mx_reg[l]   <= MAG_W'(ex_reg) * MAG_W'(ax_reg[l]);
                my_reg[l]   <= MAG_W'(ey_reg) * MAG_W'(ay_reg[l]);
                mz_reg[l]   <= MAG_W'(ez_reg) * MAG_W'(az_reg[l]);
            end
            if (s3_ready)
            begin
                pa_reg[l] <= (PROD_W+1)'(px_reg[l]) + (PROD_W+1)'(py_reg[l]);
                pb_reg[l] <= (PROD_W+1)'(pz_reg[l]) - (PROD_W+1)'(poff_reg[l]);
                pc_reg[l] <= (MAG_W+1)'(mx_reg[l]) + (MAG_W+1)'(my_reg[l]);
                pd_reg[l] <= mz_reg[l];
            end
            if (s4_ready)
            begin
                da_reg[l] <= (PROD_W+2)'(pa_reg[l]) + (PROD_W+2)'(pb_reg[l]);
                ra_reg[l] <= (MAG_W+2)'(pc_reg[l]) + (MAG_W+2)'(pd_reg[l]);
            end
        end

        // equality counts as inside
        assign lane_rej[l] = (PROD_W+3)'(da_reg[l]) > $signed({1'b0, ra_reg[l]});
    end

    always_comb
    begin
        mask_next = '0;
        mask_next[LANES-1:0] = lane_rej;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            mask_reg    <= mask_next;
            outside_reg <= |lane_rej;
        end
    end

`ifndef NO_ASSERTIONS
    a_outside_matches_mask: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.is_outside == (result.data.reject_mask != '0)))
        else $error("is_outside disagrees with reject_mask");

    a_no_mask_beyond_table: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> ((result.data.reject_mask >> LANES) == '0))
        else $error("reject bit set for a plane outside the table");

    a_no_xfer_on_held_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s2_ready) |-> !item.ready)
        else $error("input taken while the first stage is held");

    a_plane_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_xfer && (item.data.plane_index == '0)) |=>
        ((nx_reg[0] == $past(item.data.normal_x)) &&
         (off_reg[0] == $past(item.data.plane_offset))))
        else $error("plane write did not reach the table");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import bpsc_pkg::*;

    localparam int N_PLANES     = 8;
    localparam int ACC_W        = 72;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_ITEMS = 800;
    localparam int CALM_ITEMS   = 120;

    localparam logic signed [COORD_W-1:0] Q_ONE   = 32'sh0001_0000;
    localparam logic signed [COORD_W-1:0] Q_MAX   = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] Q_MIN   = 32'sh8000_0000;
    localparam logic [EXT_W-1:0]          EXT_MAX = '1;

    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] off;
    } plane_t;

    logic clk;
    logic rst_n;

    bpsc_item_if   item_ch ();
    bpsc_result_if result_ch ();

    box_plane_set_cull #(
        .NUM_PLANES (N_PLANES)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    plane_t  plane_mem [N_PLANES];
    result_t expected_results [$];
    int      error_count = 0;
    int      cycle_count = 0;
    bit      idle_on     = 1'b1;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic logic signed [ACC_W-1:0] mag_wide(input logic signed [ACC_W-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic result_t cull_box(input item_t it);
        result_t                 res;
        logic signed [ACC_W-1:0] cx, cy, cz, ex, ey, ez;
        logic signed [ACC_W-1:0] nx, ny, nz, off, acc;
        res = '0;
        cx = ACC_W'($signed(it.center_x));
        cy = ACC_W'($signed(it.center_y));
        cz = ACC_W'($signed(it.center_z));
        ex = ACC_W'(it.extent_x);
        ey = ACC_W'(it.extent_y);
        ez = ACC_W'(it.extent_z);
        for (int i = 0; i < N_PLANES; i++)
        begin
            nx  = ACC_W'($signed(plane_mem[i].nx));
            ny  = ACC_W'($signed(plane_mem[i].ny));
            nz  = ACC_W'($signed(plane_mem[i].nz));
            off = ACC_W'($signed(plane_mem[i].off));
            acc = cx * nx + cy * ny + cz * nz - (off <<< OFF_SH)
                - ex * mag_wide(nx) - ey * mag_wide(ny) - ez * mag_wide(nz);
            if (acc > 0 && i < MASK_W)
                res.reject_mask[i] = 1'b1;
        end
        res.is_outside = |res.reject_mask;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // prediction on item transfer, check on result transfer, same edge
    always @(posedge clk)
    begin
        result_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            if (item_ch.data.func == FUNC_WRITE)
            begin
                if (item_ch.data.plane_index < N_PLANES)
                begin
                    plane_mem[item_ch.data.plane_index] = '{item_ch.data.normal_x,
                        item_ch.data.normal_y, item_ch.data.normal_z,
                        item_ch.data.plane_offset};
                end
            end
            else
                expected_results.push_back(cull_box(item_ch.data));
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch($sformatf("unexpected result %p", result_ch.data));
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.data.is_outside !== want.is_outside)
                    report_mismatch($sformatf("is_outside got %b want %b",
                        result_ch.data.is_outside, want.is_outside));
                if (result_ch.data.reject_mask !== want.reject_mask)
                    report_mismatch($sformatf("reject_mask got %b want %b",
                        result_ch.data.reject_mask, want.reject_mask));
            end
        end
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("box_plane_set_cull regression: fail");
            $finish;
        end
    end

    // result side stall bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic send_item(input item_t it);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
    endtask

    function automatic item_t make_write(input int idx, input logic signed [COORD_W-1:0] nx,
                                         input logic signed [COORD_W-1:0] ny,
                                         input logic signed [COORD_W-1:0] nz,
                                         input logic signed [COORD_W-1:0] off);
        item_t it;
        it = '0;
        it.func         = FUNC_WRITE;
        it.plane_index  = IDX_W'(idx);
        it.normal_x     = nx;
        it.normal_y     = ny;
        it.normal_z     = nz;
        it.plane_offset = off;
        return it;
    endfunction

    function automatic item_t make_test(input logic signed [COORD_W-1:0] cx,
                                        input logic signed [COORD_W-1:0] cy,
                                        input logic signed [COORD_W-1:0] cz,
                                        input logic [EXT_W-1:0] ex, input logic [EXT_W-1:0] ey,
                                        input logic [EXT_W-1:0] ez);
        item_t it;
        it = '0;
        it.func     = FUNC_TEST;
        it.center_x = cx;
        it.center_y = cy;
        it.center_z = cz;
        it.extent_x = ex;
        it.extent_y = ey;
        it.extent_z = ez;
        return it;
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_coord();
        int sel;
        int v;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return $urandom();
        if (sel < 8)
        begin
            v = int'($urandom_range(0, 1 << 21)) - (1 << 20);
            return v;
        end
        case ($urandom_range(0, 4))
            0: return '0;
            1: return Q_ONE;
            2: return -Q_ONE;
            3: return Q_MAX;
            default: return Q_MIN;
        endcase
    endfunction

    function automatic logic [EXT_W-1:0] rand_extent();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return EXT_W'($urandom());
        if (sel < 8)
            return EXT_W'($urandom_range(0, 1 << 20));
        return ($urandom_range(0, 1) == 0) ? '0 : EXT_MAX;
    endfunction

    function automatic item_t rand_item();
        item_t it;
        it.func         = ($urandom_range(0, 9) < 4) ? FUNC_WRITE : FUNC_TEST;
        it.plane_index  = IDX_W'($urandom_range(0, N_PLANES - 1));
        it.normal_x     = rand_coord();
        it.normal_y     = rand_coord();
        it.normal_z     = rand_coord();
        it.plane_offset = rand_coord();
        it.center_x     = rand_coord();
        it.center_y     = rand_coord();
        it.center_z     = rand_coord();
        it.extent_x     = rand_extent();
        it.extent_y     = rand_extent();
        it.extent_z     = rand_extent();
        return it;
    endfunction

    // plane placed so that the box sits just inside, on, or just beyond it
    task automatic send_boundary_pair();
        int    kx, ky, kz, cx, cy, cz, ex, ey, ez, off;
        item_t box;
        kx  = int'($urandom_range(0, 16)) - 8;
        ky  = int'($urandom_range(0, 16)) - 8;
        kz  = int'($urandom_range(0, 16)) - 8;
        cx  = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        cy  = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        cz  = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        ex  = $urandom_range(0, 1 << 18);
        ey  = $urandom_range(0, 1 << 18);
        ez  = $urandom_range(0, 1 << 18);
        off = kx * cx + ky * cy + kz * cz
            - (kx < 0 ? -kx : kx) * ex - (ky < 0 ? -ky : ky) * ey - (kz < 0 ? -kz : kz) * ez
            + int'($urandom_range(0, 2)) - 1;
        send_item(make_write($urandom_range(0, N_PLANES - 1), kx * Q_ONE, ky * Q_ONE,
            kz * Q_ONE, off));
        box = make_test(cx, cy, cz, EXT_W'(ex), EXT_W'(ey), EXT_W'(ez));
        box.normal_x = $urandom();
        box.plane_index = IDX_W'($urandom());
        send_item(box);
    endtask

    task automatic test_empty_table();
        send_item(make_test(Q_MAX, Q_MAX, Q_MAX, '0, '0, '0));
        send_item(make_test(Q_MIN, Q_MIN, Q_MIN, EXT_MAX, EXT_MAX, EXT_MAX));
    endtask

    task automatic test_plane_edges();
        item_t it;
        send_item(make_write(0, Q_ONE, '0, '0, '0));
        it = make_test(5 * Q_ONE, '0, '0, EXT_W'(5 * Q_ONE), '0, '0);
        it.normal_x     = Q_MAX;
        it.plane_offset = Q_MIN;
        send_item(it);
        send_item(make_test(5 * Q_ONE, '0, '0, EXT_W'(5 * Q_ONE - 1), '0, '0));
        send_item(make_write(1, -Q_ONE, '0, '0, '0));
        send_item(make_test(-5 * Q_ONE, '0, '0, EXT_W'(5 * Q_ONE - 1), '0, '0));
        send_item(make_write(7, Q_MIN, Q_MIN, Q_MIN, Q_MAX));
        send_item(make_test(Q_MIN, Q_MIN, Q_MIN, EXT_MAX, EXT_MAX, EXT_MAX));
        send_item(make_test(Q_MAX, Q_MAX, Q_MAX, '0, '0, '0));
        it = make_write(3, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
        it.center_x = Q_MIN;
        it.extent_y = EXT_MAX;
        send_item(it);
        send_item(make_test(Q_MIN, Q_MIN, Q_MIN, '0, '0, '0));
        send_item(make_test(Q_MAX, Q_MAX, Q_MAX, EXT_MAX, EXT_MAX, EXT_MAX));
        send_item(make_write(0, '0, '0, '0, '0));
        send_item(make_write(1, '0, '0, '0, '0));
        send_item(make_test(5 * Q_ONE, '0, '0, EXT_W'(5 * Q_ONE - 1), '0, '0));
    endtask

    task automatic test_table_fill();
        for (int i = 0; i < N_PLANES; i++)
            send_item(make_write(i, rand_coord(), rand_coord(), rand_coord(), rand_coord()));
        send_item(make_test(rand_coord(), rand_coord(), rand_coord(),
            rand_extent(), rand_extent(), rand_extent()));
    endtask

    task automatic test_random_stream();
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            idle_on = (sent < RANDOM_ITEMS - CALM_ITEMS);
            if ($urandom_range(0, 9) == 0)
            begin
                send_boundary_pair();
                sent += 2;
            end
            else
            begin
                send_item(rand_item());
                sent++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < N_PLANES; i++)
            plane_mem[i] = '0;
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.data  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_plane_edges();
        test_table_fill();
        test_random_stream();

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("box_plane_set_cull regression: pass");
        else
            $display("box_plane_set_cull regression: fail");
        $finish;
    end

endmodule
